// ----- design/length_prefixed_frame_deframer_macros.svh -----
// Assertion macros for the length-prefixed frame deframer.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define LPFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define LPFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/lpfd_pkg.sv -----
// Package: types and constants of the length-prefixed frame deframer.
`timescale 1ns / 1ps

package lpfd_pkg;

  // Header layout, big-endian, byte offsets
  localparam int HEADER_BYTES = 20;
  localparam int HDR_IDX_W    = 5;
  typedef logic [HDR_IDX_W-1:0] hdr_idx_t;

  localparam hdr_idx_t SEQ_OFFSET   = hdr_idx_t'(4);
  localparam hdr_idx_t COUNT_OFFSET = hdr_idx_t'(12);
  localparam hdr_idx_t FLAGS_OFFSET = hdr_idx_t'(16);
  localparam hdr_idx_t HDR_LAST_IDX = hdr_idx_t'(HEADER_BYTES - 1);

  // Register map
  localparam int         PADDR_W            = 3;
  localparam logic       REG_MAX_PAYLOAD    = 1'b0;
  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65536;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [31:0] payload_length;
    logic [63:0] seq_num;
    logic [31:0] sample_total;
    logic [31:0] frame_flags;
    logic        last_of_frame;
  } result_t;

endpackage

// ----- design/length_prefixed_frame_deframer.sv -----
// Top level: length-prefixed frame deframer with skid-buffered result channel.
//
//   channel   | handshake                        | payload
//   ----------+----------------------------------+-----------------------------------
//   byte in   | byte_valid / byte_stall          | data_byte
//   result    | result_valid / result_stall      | result_kind .. last_of_frame
//   config    | APB psel/penable/pwrite/pready   | paddr, pwdata, prdata
//
// One byte is taken every cycle while byte_stall is low; its result, if any, is
// registered in the result register, or in the skid stage while the output is
// stalled. The header parse is a byte counter and shift registers.
// Reset sets max_payload_bytes to 65536 and returns the parser to the header.
// A one-item skid stage sits behind the result register: byte_stall rises only
// while that stage is occupied, i.e. after the result side has stalled.
`timescale 1ns / 1ps
`include "length_prefixed_frame_deframer_macros.svh"

module length_prefixed_frame_deframer
  import lpfd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // byte input
  input  logic                byte_valid,
  output logic                byte_stall,
  input  logic [7:0]          data_byte,
  // result output
  output logic                result_valid,
  input  logic                result_stall,
  output logic [1:0]          result_kind,
  output logic [7:0]          payload_byte,
  output logic [31:0]         payload_length,
  output logic [63:0]         seq_num,
  output logic [31:0]         sample_total,
  output logic [31:0]         frame_flags,
  output logic                last_of_frame,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_ERROR   = 2'd2
  } phase_t;

  phase_t      phase, phase_next;
  hdr_idx_t    header_index, header_index_next;
  logic [31:0] length_reg, length_next;
  logic [63:0] sequence_reg, sequence_next;
  logic [31:0] count_reg, count_next;
  logic [31:0] flags_reg, flags_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;
  logic [31:0] max_payload_bytes;

  result_t     out_reg, skid_reg, res;
  logic        out_valid, skid_valid, res_valid;
  logic        byte_take, out_take, cfg_write;

  assign byte_take = byte_valid && !byte_stall;
  assign out_take  = out_valid && !result_stall;
  assign byte_stall = skid_valid;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[PADDR_W-1] == REG_MAX_PAYLOAD) ? max_payload_bytes : 32'd0;

  // Parse one byte: header shift, length check, payload count
  always_comb begin
    phase_next           = phase;
    header_index_next    = header_index;
    length_next          = length_reg;
    sequence_next        = sequence_reg;
    count_next           = count_reg;
    flags_next           = flags_reg;
    bytes_remaining_next = bytes_remaining;
    res_valid            = 1'b0;
    res.kind             = KIND_HEADER;
    res.payload_byte     = 8'd0;
    res.last_of_frame    = 1'b0;

    case (phase)
      PH_HEADER: begin
        if (header_index < SEQ_OFFSET) begin
          length_next = {length_reg[23:0], data_byte};
        end else if (header_index < COUNT_OFFSET) begin
          sequence_next = {sequence_reg[55:0], data_byte};
        end else if (header_index < FLAGS_OFFSET) begin
          count_next = {count_reg[23:0], data_byte};
        end else begin
          flags_next = {flags_reg[23:0], data_byte};
        end

        if (header_index != HDR_LAST_IDX) begin
          header_index_next = header_index + hdr_idx_t'(1);
        end else begin
          header_index_next = '0;
          res_valid         = 1'b1;
          // length bytes are complete well before the last header byte
          if (length_reg > max_payload_bytes) begin
            phase_next = PH_ERROR;
            res.kind   = KIND_ERROR;
          end else if (length_reg == 32'd0) begin
            res.last_of_frame = 1'b1;
          end else begin
            bytes_remaining_next = length_reg;
            phase_next           = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        res_valid        = 1'b1;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = data_byte;
        if (bytes_remaining <= 32'd1) begin
          bytes_remaining_next = 32'd0;
          phase_next           = PH_HEADER;
          res.last_of_frame    = 1'b1;
        end else begin
          bytes_remaining_next = bytes_remaining - 32'd1;
        end
      end
      default: begin
        // sticky error: bytes are dropped
      end
    endcase

    res.payload_length = length_next;
    res.seq_num        = sequence_next;
    res.sample_total   = count_next;
    res.frame_flags    = flags_next;
  end

  // State, config register and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      header_index      <= '0;
      max_payload_bytes <= MAX_PAYLOAD_RESET;
      out_valid         <= 1'b0;
      skid_valid        <= 1'b0;
    end else begin
      if (cfg_write && paddr[PADDR_W-1] == REG_MAX_PAYLOAD) begin
        max_payload_bytes <= pwdata;
      end

      if (byte_take) begin
        phase        <= phase_next;
        header_index <= header_index_next;
      end

      // skid occupied implies no byte is taken this cycle
      if (skid_valid) begin
        if (out_take) begin
          out_reg    <= skid_reg;
          skid_valid <= 1'b0;
        end
      end else if (byte_take && res_valid) begin
        if (!out_valid || out_take) begin
          out_reg   <= res;
          out_valid <= 1'b1;
        end else begin
          skid_reg   <= res;
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end

    if (byte_take) begin
      length_reg      <= length_next;
      sequence_reg    <= sequence_next;
      count_reg       <= count_next;
      flags_reg       <= flags_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

  // Result ports
  assign result_valid   = out_valid;
  assign result_kind    = out_reg.kind;
  assign payload_byte   = out_reg.payload_byte;
  assign payload_length = out_reg.payload_length;
  assign seq_num        = out_reg.seq_num;
  assign sample_total   = out_reg.sample_total;
  assign frame_flags    = out_reg.frame_flags;
  assign last_of_frame  = out_reg.last_of_frame;

  // Checks
  `LPFD_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_valid, out_valid, "skid full, output empty")
  `LPFD_ASSERT_NEXT(a_error_sticky, clk, rst, phase == PH_ERROR, phase == PH_ERROR, "error left")
  `LPFD_ASSERT_NOW(a_idx_in_hdr, clk, rst, header_index != '0, phase == PH_HEADER, "index off header")

endmodule

// ----- tb/length_prefixed_frame_deframer_checker.sv -----
// Checker: watches the byte, result and register channels, predicts each result and compares.
`timescale 1ns / 1ps

module length_prefixed_frame_deframer_checker
  import lpfd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  input  logic                byte_stall,
  input  logic [7:0]          data_byte,
  input  logic                result_valid,
  input  logic                result_stall,
  input  logic [1:0]          result_kind,
  input  logic [7:0]          payload_byte,
  input  logic [31:0]         payload_length,
  input  logic [63:0]         seq_num,
  input  logic [31:0]         sample_total,
  input  logic [31:0]         frame_flags,
  input  logic                last_of_frame,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output int                  fail_count,
  output int                  results_due
);

  typedef enum logic [1:0] {
    ST_HEADER,
    ST_PAYLOAD,
    ST_DROP
  } parse_state_t;

  // Shadow of the parser and of the size limit
  parse_state_t state;
  hdr_idx_t     hdr_pos;
  logic [31:0]  len_acc;
  logic [63:0]  seq_acc;
  logic [31:0]  cnt_acc;
  logic [31:0]  flg_acc;
  logic [31:0]  body_left;
  logic [31:0]  max_len;

  result_t      due_results[$];
  result_t      want;
  int           fails = 0;

  task automatic check_field(input string fname, input logic [63:0] exp_val,
                             input logic [63:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", fname, exp_val, got_val);
      fails++;
    end
  endtask

  // Predict what one accepted byte gives, if anything
  task automatic deframe_byte(input logic [7:0] b);
    result_t r;
    logic    gives_result;
    gives_result    = 1'b0;
    r.kind          = KIND_HEADER;
    r.payload_byte  = 8'h00;
    r.last_of_frame = 1'b0;
    case (state)
      ST_HEADER: begin
        if (hdr_pos < SEQ_OFFSET) len_acc = {len_acc[23:0], b};
        else if (hdr_pos < COUNT_OFFSET) seq_acc = {seq_acc[55:0], b};
        else if (hdr_pos < FLAGS_OFFSET) cnt_acc = {cnt_acc[23:0], b};
        else flg_acc = {flg_acc[23:0], b};
        if (hdr_pos != HDR_LAST_IDX) begin
          hdr_pos = hdr_pos + 1'b1;
        end else begin
          hdr_pos      = '0;
          gives_result = 1'b1;
          if (len_acc > max_len) begin
            // oversize: sticky until reset
            state  = ST_DROP;
            r.kind = KIND_ERROR;
          end else if (len_acc == 32'd0) begin
            r.last_of_frame = 1'b1;
          end else begin
            body_left = len_acc;
            state     = ST_PAYLOAD;
          end
        end
      end
      ST_PAYLOAD: begin
        gives_result   = 1'b1;
        r.kind         = KIND_PAYLOAD;
        r.payload_byte = b;
        if (body_left <= 32'd1) begin
          body_left       = '0;
          state           = ST_HEADER;
          r.last_of_frame = 1'b1;
        end else begin
          body_left = body_left - 1'b1;
        end
      end
      default: ;
    endcase
    if (gives_result) begin
      r.payload_length = len_acc;
      r.seq_num        = seq_acc;
      r.sample_total   = cnt_acc;
      r.frame_flags    = flg_acc;
      due_results.insert(due_results.size(), r);
    end
  endtask

  // Results first: a result never belongs to the byte taken at the same edge
  always @(posedge clk) begin
    if (rst) begin
      state     = ST_HEADER;
      hdr_pos   = '0;
      len_acc   = '0;
      seq_acc   = '0;
      cnt_acc   = '0;
      flg_acc   = '0;
      body_left = '0;
      max_len   = MAX_PAYLOAD_RESET;
      due_results.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (due_results.size() == 0) begin
          $error("result item with none expected: kind %0d", result_kind);
          fails++;
        end else begin
          want = due_results.pop_front();
          check_field("result_kind", want.kind, result_kind);
          check_field("payload_byte", want.payload_byte, payload_byte);
          check_field("payload_length", want.payload_length, payload_length);
          check_field("seq_num", want.seq_num, seq_num);
          check_field("sample_total", want.sample_total, sample_total);
          check_field("frame_flags", want.frame_flags, frame_flags);
          check_field("last_of_frame", want.last_of_frame, last_of_frame);
        end
      end
      if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_MAX_PAYLOAD)
        max_len = pwdata;
      if (byte_valid && !byte_stall) deframe_byte(data_byte);
    end
    fail_count  <= fails;
    results_due <= due_results.size();
  end

endmodule

// ----- tb/tb_length_prefixed_frame_deframer.sv -----
// Testbench top: drives framed bytes and register writes into the deframer and gives the verdict.
`timescale 1ns / 1ps

module tb_length_prefixed_frame_deframer;
  import lpfd_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 80;
  localparam int SEG_BYTES     = 240;
  localparam logic [PADDR_W-1:0] ADDR_MAX_PAYLOAD = {REG_MAX_PAYLOAD, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_OUT_OF_MAP  = {~REG_MAX_PAYLOAD, 2'b00};

  logic                clk;
  logic                rst;
  logic                byte_valid;
  logic                byte_stall;
  logic [7:0]          data_byte;
  logic                result_valid;
  logic                result_stall;
  logic [1:0]          result_kind;
  logic [7:0]          payload_byte;
  logic [31:0]         payload_length;
  logic [63:0]         seq_num;
  logic [31:0]         sample_total;
  logic [31:0]         frame_flags;
  logic                last_of_frame;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  int snd_idle;
  int rcv_idle;
  int holds_asked;
  int holds_done;
  int bytes_sent;
  int cfg_fails;
  int check_fails;
  int results_due;

  length_prefixed_frame_deframer i_dut (
    .clk             (clk),
    .rst             (rst),
    .byte_valid      (byte_valid),
    .byte_stall      (byte_stall),
    .data_byte       (data_byte),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result_kind     (result_kind),
    .payload_byte    (payload_byte),
    .payload_length  (payload_length),
    .seq_num         (seq_num),
    .sample_total    (sample_total),
    .frame_flags     (frame_flags),
    .last_of_frame   (last_of_frame),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  length_prefixed_frame_deframer_checker i_deframer_check (
    .clk             (clk),
    .rst             (rst),
    .byte_valid      (byte_valid),
    .byte_stall      (byte_stall),
    .data_byte       (data_byte),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result_kind     (result_kind),
    .payload_byte    (payload_byte),
    .payload_length  (payload_length),
    .seq_num         (seq_num),
    .sample_total    (sample_total),
    .frame_flags     (frame_flags),
    .last_of_frame   (last_of_frame),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .fail_count      (check_fails),
    .results_due     (results_due)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("[length_prefixed_frame_deframer] ERROR");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off when asked
  initial begin
    result_stall = 1'b0;
    holds_done   = 0;
    forever begin
      @(negedge clk);
      if (holds_done < holds_asked) begin
        holds_done++;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        result_stall <= ($urandom_range(0, 99) < rcv_idle);
      end
    end
  end

  // One item on the byte channel; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < snd_idle) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    data_byte  <= b;
    do @(posedge clk); while (byte_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_header(input logic [159:0] hdr, input int first_idx, input int last_idx);
    for (int k = first_idx; k <= last_idx; k++) send_byte(hdr[159 - 8*k -: 8]);
  endtask

  task automatic send_payload(input logic [31:0] n);
    repeat (n) send_byte(8'($urandom));
  endtask

  task automatic send_frame(input logic [31:0] len, input logic [63:0] seq,
                            input logic [31:0] cnt, input logic [31:0] flg);
    send_header({len, seq, cnt, flg}, 0, HEADER_BYTES - 1);
    send_payload(len);
  endtask

  // Mostly short payloads, some empty, now and then exactly at the limit when it is below 200
  function automatic logic [31:0] pick_len(input logic [31:0] cap);
    int unsigned roll;
    logic [31:0] n;
    roll = $urandom_range(0, 99);
    if (roll < 20) n = '0;
    else if (roll < 75) n = $urandom_range(1, 12);
    else if (roll < 95) n = $urandom_range(13, 48);
    else n = (cap < 200) ? cap : $urandom_range(49, 200);
    if (n > cap) n = cap;
    return n;
  endfunction

  task automatic random_frame(input logic [31:0] cap);
    send_frame(pick_len(cap), {$urandom, $urandom}, $urandom, $urandom);
  endtask

  // Stop offering bytes and let every expected result drain
  task automatic wait_drained();
    byte_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register access: setup, access, then idle with psel low
  task automatic reg_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_max(input logic [31:0] value);
    logic [31:0] rd;
    wait_drained();
    reg_access(1'b1, ADDR_MAX_PAYLOAD, value, rd);
    reg_access(1'b0, ADDR_MAX_PAYLOAD, '0, rd);
    if (rd !== value) begin
      $error("max_payload_bytes readback: expected %0h, got %0h", value, rd);
      cfg_fails++;
    end
  endtask

  // Stimulus and verdict
  initial begin
    logic [159:0] hdr;
    logic [31:0]  rd;
    logic [31:0]  cap;
    int           seg_start;
    rst         = 1'b1;
    byte_valid  = 1'b0;
    data_byte   = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    snd_idle    = 10;
    rcv_idle    = 84;
    holds_asked = 0;
    bytes_sent  = 0;
    cfg_fails   = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Limit of zero: only empty frames pass, header fields at both extremes
    write_max('0);
    send_frame('0, '1, '1, '1);
    send_frame('0, '0, '0, '0);

    // Length equal to the limit; a write outside the map must not touch it
    write_max(32'd5);
    reg_access(1'b1, ADDR_OUT_OF_MAP, '0, rd);
    send_header({32'd5, 64'h0123_4567_89ab_cdef, 32'h8000_0001, 32'hdead_beef}, 0, 19);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h55);
    send_byte(8'haa);
    send_byte(8'h80);
    send_frame(32'd1, {$urandom, $urandom}, $urandom, $urandom);

    // Limit raised part-way through a header: the new value decides
    hdr = {32'd6, 64'hfedc_ba98_7654_3210, 32'h0000_ffff, 32'h5a5a_a5a5};
    send_header(hdr, 0, 9);
    write_max(32'd6);
    send_header(hdr, 10, 19);
    send_payload(32'd6);

    // Random frames, sender mostly busy and receiver mostly stalled
    write_max(MAX_PAYLOAD_RESET);
    seg_start = bytes_sent;
    while (bytes_sent - seg_start < SEG_BYTES) random_frame(MAX_PAYLOAD_RESET);

    // Sender mostly idle, receiver mostly ready, no limit in practice
    write_max('1);
    snd_idle  = 84;
    rcv_idle  = 10;
    seg_start = bytes_sent;
    while (bytes_sent - seg_start < SEG_BYTES) random_frame('1);

    // Full rate with a long hold-off on the result side, small limit
    cap = $urandom_range(8, 40);
    write_max(cap);
    snd_idle  = 0;
    rcv_idle  = 0;
    holds_asked++;
    seg_start = bytes_sent;
    while (bytes_sent - seg_start < SEG_BYTES) random_frame(cap);

    // Oversize length: error item, then every byte is dropped
    write_max(32'hffff_fffe);
    snd_idle = 10;
    rcv_idle = 50;
    send_header({32'hffff_ffff, {$urandom, $urandom}, $urandom, $urandom}, 0, 19);
    repeat (40) send_byte(8'($urandom));
    wait_drained();

    if (check_fails + cfg_fails == 0) begin
      $display("[length_prefixed_frame_deframer] OK");
    end else begin
      $display("[length_prefixed_frame_deframer] ERROR");
    end
    $finish;
  end

endmodule
